>>> sv/hbd_pkg.sv
// Shared types, codes and sizes of the Huffman tree bit decoder.
`default_nettype none

package hbd_pkg;

  // Depth of the node table and the width of its address.
  localparam int unsigned NODE_COUNT = 512;
  localparam int unsigned ADDR_W     = $clog2(NODE_COUNT);

  localparam int unsigned IDX_W = 9;
  localparam int unsigned SYM_W = 8;

  localparam logic [SYM_W-1:0] END_SYMBOL = 8'hFF;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_DECODE = 2'd1,
    OP_START  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HERE,
    ST_CHILD
  } state_e;

  typedef struct packed {
    logic             leaf;
    logic [SYM_W-1:0] symbol;
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
  } node_t;

  localparam int unsigned NODE_W = $bits(node_t);

  // True when a node index falls inside the table.
  function automatic logic idx_ok(logic [IDX_W-1:0] idx);
    return 32'(idx) < NODE_COUNT;
  endfunction

endpackage

`default_nettype wire

>>> sv/hbd_node_ram.sv
// Node table memory: one write port, one read port with registered read data.
`default_nettype none

module hbd_node_ram #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned WIDTH = 27
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> sv/huffman_tree_bit_decoder_unit.sv
// Huffman decoder that walks a code tree stored in a node table, one code bit per word.
//
// The input channel (in_valid_i/in_ready_o) carries words of three kinds: a node table
// write, a code bit to decode, or a start of a new message. The output channel
// (out_valid_o/out_ready_i) carries one decoded symbol word, flagged when it is the
// end marker. The root register is written through cfg_we_i/cfg_wdata_i at any time
// the block is idle; it takes effect at the next start or return to the root.
// Writes and starts complete in the idle state as they are accepted. A code bit goes
// straight to the child read while the node the walk stands on is held in the local
// node register. Right after a start, a decoded symbol or a write to that node, it
// first fetches that node (no child read when the fetched node is itself a leaf). The
// steps follow the dependent node table reads: each read is registered and the child
// address comes from the previous read. The decoded symbol is loaded into the output
// register from the leaf node as soon as that register is free.
// After reset the walk stands at node 0 with the root at 0; the node table holds
// nothing until written. A waiting output word does not block new input words; only
// a code bit that completes a symbol waits, holding its read data, until the output
// register frees up.
`default_nettype none

module huffman_tree_bit_decoder_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [1:0]                   op_i,
  input  wire logic [hbd_pkg::IDX_W-1:0]    node_index_i,
  input  wire logic                         is_leaf_i,
  input  wire logic [hbd_pkg::SYM_W-1:0]    leaf_symbol_i,
  input  wire logic [hbd_pkg::IDX_W-1:0]    left_child_i,
  input  wire logic [hbd_pkg::IDX_W-1:0]    right_child_i,
  input  wire logic                         code_bit_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic      [hbd_pkg::SYM_W-1:0]    symbol_out_o,
  output logic                              end_of_message_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [hbd_pkg::IDX_W-1:0]    cfg_wdata_i
);

  localparam int unsigned AW = hbd_pkg::ADDR_W;

  hbd_pkg::state_e state_q, state_d;
  logic [hbd_pkg::IDX_W-1:0] current_q, current_d;
  logic [hbd_pkg::IDX_W-1:0] root_q;
  logic                      stopped_q, stopped_d;
  hbd_pkg::node_t            here_q, here_d;
  logic                      here_valid_q, here_valid_d;
  logic                      here_hit_q, here_hit_d;
  logic [hbd_pkg::IDX_W-1:0] next_q, next_d;
  logic                      bit_q, bit_d;
  logic                      rd_ok_q;
  logic                      out_valid_q, out_valid_d;
  logic [hbd_pkg::SYM_W-1:0] sym_q, sym_d;
  logic                      eom_q, eom_d;

  logic                      accept;
  logic                      out_free;
  logic                      out_load;
  logic                      wr_en;
  logic                      rd_en;
  logic [hbd_pkg::IDX_W-1:0] rd_idx;
  logic [hbd_pkg::NODE_W-1:0] rd_data;
  hbd_pkg::node_t            rd_ent;
  hbd_pkg::node_t            here_ent;
  hbd_pkg::node_t            wr_ent;

  assign in_ready_o = (state_q == hbd_pkg::ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // Reads beyond the table see an all-zero node.
  assign rd_ent   = rd_ok_q ? hbd_pkg::node_t'(rd_data) : '0;
  assign here_ent = here_hit_q ? here_q : rd_ent;

  assign wr_ent = '{leaf: is_leaf_i, symbol: leaf_symbol_i,
                    left: left_child_i, right: right_child_i};

  hbd_node_ram #(
    .DEPTH (hbd_pkg::NODE_COUNT),
    .WIDTH (hbd_pkg::NODE_W)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (AW'(node_index_i)),
    .wdata_i (wr_ent),
    .re_i    (rd_en),
    .raddr_i (AW'(rd_idx)),
    .rdata_o (rd_data)
  );

  always_comb begin
    state_d      = state_q;
    current_d    = current_q;
    stopped_d    = stopped_q;
    here_d       = here_q;
    here_valid_d = here_valid_q;
    here_hit_d   = here_hit_q;
    next_d       = next_q;
    bit_d        = bit_q;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    rd_idx       = current_q;
    out_load     = 1'b0;
    sym_d        = sym_q;

    unique case (state_q)
      hbd_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (hbd_pkg::op_e'(op_i))
            hbd_pkg::OP_WRITE: begin
              wr_en = hbd_pkg::idx_ok(node_index_i);
              if (node_index_i == current_q) begin
                here_valid_d = 1'b0;
              end
            end
            hbd_pkg::OP_START: begin
              current_d    = root_q;
              stopped_d    = 1'b0;
              here_valid_d = 1'b0;
            end
            hbd_pkg::OP_DECODE: begin
              if (!stopped_q) begin
                if (here_valid_q && here_q.leaf) begin
                  here_hit_d = 1'b1;
                  state_d    = hbd_pkg::ST_HERE;
                end else if (here_valid_q) begin
                  // The current node is already held, so go straight to its child.
                  rd_en   = 1'b1;
                  rd_idx  = code_bit_i ? here_q.right : here_q.left;
                  next_d  = rd_idx;
                  state_d = hbd_pkg::ST_CHILD;
                end else begin
                  rd_en      = 1'b1;
                  rd_idx     = current_q;
                  bit_d      = code_bit_i;
                  here_hit_d = 1'b0;
                  state_d    = hbd_pkg::ST_HERE;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      hbd_pkg::ST_HERE: begin
        here_d       = here_ent;
        here_valid_d = 1'b1;
        if (here_ent.leaf) begin
          // A leaf at the walk position repeats its symbol without moving.
          here_hit_d = 1'b1;
          if (out_free) begin
            out_load     = 1'b1;
            sym_d        = here_ent.symbol;
            current_d    = root_q;
            here_valid_d = 1'b0;
            here_hit_d   = 1'b0;
            state_d      = hbd_pkg::ST_IDLE;
          end
        end else begin
          rd_en   = 1'b1;
          rd_idx  = bit_q ? here_ent.right : here_ent.left;
          next_d  = rd_idx;
          state_d = hbd_pkg::ST_CHILD;
        end
      end
      hbd_pkg::ST_CHILD: begin
        if (rd_ent.leaf) begin
          if (out_free) begin
            out_load     = 1'b1;
            sym_d        = rd_ent.symbol;
            current_d    = root_q;
            here_valid_d = 1'b0;
            state_d      = hbd_pkg::ST_IDLE;
          end
        end else begin
          current_d    = next_q;
          here_d       = rd_ent;
          here_valid_d = 1'b1;
          state_d      = hbd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = hbd_pkg::ST_IDLE;
      end
    endcase

    eom_d = eom_q;
    if (out_load) begin
      eom_d = (sym_d == hbd_pkg::END_SYMBOL);
      if (eom_d) begin
        stopped_d = 1'b1;
      end
    end

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= hbd_pkg::ST_IDLE;
      current_q    <= '0;
      root_q       <= '0;
      stopped_q    <= 1'b0;
      here_valid_q <= 1'b0;
      here_hit_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      current_q    <= current_d;
      stopped_q    <= stopped_d;
      here_valid_q <= here_valid_d;
      here_hit_q   <= here_hit_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        root_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    here_q <= here_d;
    next_q <= next_d;
    bit_q  <= bit_d;
    sym_q  <= sym_d;
    eom_q  <= eom_d;
    if (rd_en) begin
      rd_ok_q <= hbd_pkg::idx_ok(rd_idx);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign symbol_out_o     = sym_q;
  assign end_of_message_o = eom_q;

`ifndef ASSERT_OFF
  // A stopped walk never touches the node table for a code bit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == hbd_pkg::ST_IDLE && stopped_q) |-> !rd_en)
    else $error("node read issued while stopped");

  // Every decoded symbol sends the walk back to the root, so the held node is dropped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (!here_valid_q && current_q == $past(root_q)))
    else $error("walk did not return to the root after a symbol");

  // The held node is only used in place of the memory when it is a leaf.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == hbd_pkg::ST_HERE && here_hit_q) |-> here_q.leaf)
    else $error("held node used although it is not a leaf");

  // A new symbol is never loaded over one the receiver has not taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !out_load)
    else $error("output word overwritten while stalled");
`endif

endmodule

`default_nettype wire

>>> tb/hbd_symbol_checker.sv
// Tracks the decoder's tree walk, predicts every symbol word and checks the output channel.
module hbd_symbol_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic [1:0]                op_i,
  input  logic [hbd_pkg::IDX_W-1:0] node_index_i,
  input  logic                      is_leaf_i,
  input  logic [hbd_pkg::SYM_W-1:0] leaf_symbol_i,
  input  logic [hbd_pkg::IDX_W-1:0] left_child_i,
  input  logic [hbd_pkg::IDX_W-1:0] right_child_i,
  input  logic                      code_bit_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic [hbd_pkg::SYM_W-1:0] symbol_out_i,
  input  logic                      end_of_message_i,
  input  logic                      cfg_we_i,
  input  logic [hbd_pkg::IDX_W-1:0] cfg_wdata_i,
  output int unsigned               fail_count_o,
  output int unsigned               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import hbd_pkg::*;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             end_flag;
  } symbol_word_t;

  node_t            tree_mem [NODE_COUNT];
  logic [IDX_W-1:0] walk_node;
  logic [IDX_W-1:0] root_reg;
  logic             halted;
  symbol_word_t     awaited_symbols [$];
  int unsigned      mismatches = 0;

  // Applies one input word to the shadow tree and walk, queueing any symbol it decodes.
  function automatic void advance_walk(input logic [1:0] op, input logic [IDX_W-1:0] idx,
                                       input logic leaf, input logic [SYM_W-1:0] sym,
                                       input logic [IDX_W-1:0] left, input logic [IDX_W-1:0] right,
                                       input logic code_bit);
    node_t            here;
    node_t            hit;
    logic [IDX_W-1:0] next;
    logic             found;
    found = 1'b0;
    case (op)
      OP_WRITE: begin
        tree_mem[idx] = {leaf, sym, left, right};
      end
      OP_START: begin
        walk_node = root_reg;
        halted    = 1'b0;
      end
      OP_DECODE: begin
        if (!halted) begin
          here = tree_mem[walk_node];
          // A walk standing on a leaf emits it without moving.
          if (here.leaf) begin
            hit   = here;
            found = 1'b1;
          end else begin
            next = code_bit ? here.right : here.left;
            hit  = tree_mem[next];
            if (hit.leaf) begin
              found = 1'b1;
            end else begin
              walk_node = next;
            end
          end
          if (found) begin
            walk_node = root_reg;
            if (hit.symbol == END_SYMBOL) begin
              halted = 1'b1;
            end
            awaited_symbols.push_back('{symbol: hit.symbol, end_flag: hit.symbol == END_SYMBOL});
          end
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk_i) begin
    symbol_word_t want;
    if (!rst_ni) begin
      walk_node = '0;
      root_reg  = '0;
      halted    = 1'b0;
    end else begin
      if (cfg_we_i) begin
        root_reg = cfg_wdata_i;
      end
      if (in_valid_i && in_ready_i) begin
        advance_walk(op_i, node_index_i, is_leaf_i, leaf_symbol_i, left_child_i, right_child_i,
                     code_bit_i);
      end
      if (out_valid_i && out_ready_i) begin
        if (awaited_symbols.size() == 0) begin
          $error("symbol word %0d (end %0b) with none expected", symbol_out_i, end_of_message_i);
          mismatches++;
        end else begin
          want = awaited_symbols.pop_front();
          if (symbol_out_i !== want.symbol) begin
            $error("symbol_out: expected %0d, actual %0d", want.symbol, symbol_out_i);
            mismatches++;
          end
          if (end_of_message_i !== want.end_flag) begin
            $error("end_of_message: expected %0b, actual %0b", want.end_flag, end_of_message_i);
            mismatches++;
          end
        end
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= $unsigned(awaited_symbols.size());
  end

endmodule

>>> tb/tb_huffman_tree_bit_decoder_unit.sv
// Stimulus and verdict for the Huffman tree bit decoder: builds code trees and feeds code bits.
module tb_huffman_tree_bit_decoder_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import hbd_pkg::*;

  localparam logic [1:0]  OP_UNUSED        = 2'd3;
  localparam int unsigned WORD_TARGET      = 750;
  localparam int unsigned CALM_AFTER       = 650;
  localparam int unsigned LONG_HOLD_CYCLES = 120;
  localparam int unsigned SETTLE_CYCLES    = 10;
  localparam int unsigned DRAIN_CYCLES     = 20;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [1:0]       op;
  logic [IDX_W-1:0] node_index;
  logic             is_leaf;
  logic [SYM_W-1:0] leaf_symbol;
  logic [IDX_W-1:0] left_child;
  logic [IDX_W-1:0] right_child;
  logic             code_bit;
  logic             out_valid;
  logic             out_ready;
  logic [SYM_W-1:0] symbol_out;
  logic             end_of_message;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_wdata;
  int unsigned      fail_count;
  int unsigned      pending;

  bit               gaps_on = 1'b1;
  bit               hold_request = 1'b0;
  int unsigned      words_sent = 0;
  bit               filled_map [NODE_COUNT];
  logic [IDX_W-1:0] filled_nodes [$];

  huffman_tree_bit_decoder_unit DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .op_i            (op),
    .node_index_i    (node_index),
    .is_leaf_i       (is_leaf),
    .leaf_symbol_i   (leaf_symbol),
    .left_child_i    (left_child),
    .right_child_i   (right_child),
    .code_bit_i      (code_bit),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .symbol_out_o    (symbol_out),
    .end_of_message_o(end_of_message),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata)
  );

  hbd_symbol_checker symbol_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .op_i            (op),
    .node_index_i    (node_index),
    .is_leaf_i       (is_leaf),
    .leaf_symbol_i   (leaf_symbol),
    .left_child_i    (left_child),
    .right_child_i   (right_child),
    .code_bit_i      (code_bit),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .symbol_out_i    (symbol_out),
    .end_of_message_i(end_of_message),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("Some tests failed");
    $finish;
  end

  // Output side: short random stalls, plus one long hold-off when the stimulus asks for it.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
        out_ready <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_word(input logic [1:0] w_op, input logic [IDX_W-1:0] w_index,
                           input logic w_leaf, input logic [SYM_W-1:0] w_symbol,
                           input logic [IDX_W-1:0] w_left, input logic [IDX_W-1:0] w_right,
                           input logic w_bit);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    op          <= w_op;
    node_index  <= w_index;
    is_leaf     <= w_leaf;
    leaf_symbol <= w_symbol;
    left_child  <= w_left;
    right_child <= w_right;
    code_bit    <= w_bit;
    do @(posedge clk); while (!in_ready);
    if (w_op != OP_UNUSED) begin
      words_sent++;
    end
  endtask

  // Every written node points only at written nodes, so no walk ever reads an empty entry.
  task automatic write_node(input logic [IDX_W-1:0] idx, input logic leaf,
                            input logic [SYM_W-1:0] sym, input logic [IDX_W-1:0] left,
                            input logic [IDX_W-1:0] right);
    send_word(OP_WRITE, idx, leaf, sym, left, right, 1'($urandom));
    if (!filled_map[idx]) begin
      filled_map[idx] = 1'b1;
      filled_nodes.push_back(idx);
    end
  endtask

  task automatic send_bit(input logic b);
    send_word(OP_DECODE, IDX_W'($urandom), 1'($urandom), SYM_W'($urandom), IDX_W'($urandom),
              IDX_W'($urandom), b);
  endtask

  task automatic send_start();
    send_word(OP_START, IDX_W'($urandom), 1'($urandom), SYM_W'($urandom), IDX_W'($urandom),
              IDX_W'($urandom), 1'($urandom));
  endtask

  task automatic send_noise();
    send_word(OP_UNUSED, IDX_W'($urandom), 1'($urandom), SYM_W'($urandom), IDX_W'($urandom),
              IDX_W'($urandom), 1'($urandom));
  endtask

  function automatic logic [IDX_W-1:0] pick_filled();
    return filled_nodes[$urandom_range(0, filled_nodes.size() - 1)];
  endfunction

  // The root may only change once the block is idle and every symbol word has drained.
  task automatic set_root(input logic [IDX_W-1:0] value);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Builds a full binary tree bottom-up at fresh random indices, leaves first.
  task automatic plant_tree(input int unsigned n_leaves, input bit with_end,
                            output logic [IDX_W-1:0] top_node);
    logic [IDX_W-1:0] subtrees [$];
    bit               taken [NODE_COUNT];
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    int unsigned      pos;
    for (int unsigned i = 0; i < 2 * n_leaves - 1; i++) begin
      do idx = IDX_W'($urandom); while (taken[idx]);
      taken[idx] = 1'b1;
      if (i < n_leaves) begin
        write_node(idx, 1'b1, (with_end && i == 0) ? END_SYMBOL : SYM_W'($urandom_range(0, 254)),
                   pick_filled(), pick_filled());
      end else begin
        pos = $urandom_range(0, subtrees.size() - 1);
        a = subtrees[pos];
        subtrees.delete(pos);
        pos = $urandom_range(0, subtrees.size() - 1);
        b = subtrees[pos];
        subtrees.delete(pos);
        write_node(idx, 1'b0, SYM_W'($urandom), a, b);
      end
      subtrees.push_back(idx);
    end
    top_node = subtrees[0];
  endtask

  initial begin
    logic [IDX_W-1:0] root;
    int unsigned      phase;
    int unsigned      n_leaves;
    bit               hold_phase;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    op          <= OP_WRITE;
    node_index  <= '0;
    is_leaf     <= 1'b0;
    leaf_symbol <= '0;
    left_child  <= '0;
    right_child <= '0;
    code_bit    <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_wdata   <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Small hand-made tree: leaves at the two ends of the table, internal nodes above them.
    write_node(IDX_W'(0), 1'b1, 8'h00, IDX_W'(0), IDX_W'(0));
    write_node(IDX_W'(511), 1'b1, END_SYMBOL, IDX_W'(511), IDX_W'(511));
    write_node(IDX_W'(1), 1'b0, 8'hAA, IDX_W'(0), IDX_W'(511));
    write_node(IDX_W'(2), 1'b0, 8'h55, IDX_W'(511), IDX_W'(0));
    write_node(IDX_W'(3), 1'b0, 8'h3C, IDX_W'(1), IDX_W'(2));
    send_noise();
    // Out of reset the walk stands on leaf node 0, which emits for every bit.
    send_bit(1'b0);
    send_bit(1'b1);
    // A new root only takes effect on the next return to the root.
    set_root(IDX_W'(1));
    send_bit(1'b1);
    send_bit(1'b0);
    send_bit(1'b1);
    send_bit(1'b0);
    send_start();
    send_bit(1'b1);
    // A root that is itself the end marker leaf.
    set_root(IDX_W'(511));
    send_start();
    send_bit(1'b0);
    send_bit(1'b1);
    set_root(IDX_W'(3));
    send_start();
    send_bit(1'b0);
    send_bit(1'b0);
    send_bit(1'b1);
    send_bit(1'b0);

    phase = 0;
    while (words_sent < WORD_TARGET) begin
      phase++;
      gaps_on = (words_sent < CALM_AFTER) && ($urandom_range(0, 3) != 0);
      hold_phase = (phase == 4 || phase == 13);
      if (hold_phase || $urandom_range(0, 7) == 0) begin
        n_leaves = 1;
      end else begin
        n_leaves = $urandom_range(2, 8);
      end
      plant_tree(n_leaves, !hold_phase && $urandom_range(0, 2) == 0, root);
      set_root(root);
      send_start();
      if (hold_phase) begin
        // A single-leaf root makes every bit a symbol word, so the block backs up quickly.
        hold_request = 1'b1;
        repeat (30) send_bit(1'($urandom));
      end else begin
        repeat ($urandom_range(15, 40)) begin
          case ($urandom_range(0, 19))
            0:       send_noise();
            1:       send_start();
            2:       write_node(IDX_W'($urandom), 1'($urandom), SYM_W'($urandom), pick_filled(),
                                pick_filled());
            default: send_bit(1'($urandom));
          endcase
        end
      end
    end

    gaps_on = 1'b0;
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
